// ----- hw/rtl/cfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cfd_pkg;

	localparam int FRAME_LEN = 13;
	localparam int CRC_LEN   = 4;
	localparam int BODY_LEN  = FRAME_LEN - CRC_LEN;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_CRC_ERR  = 3'd1;
	localparam logic [2:0] ST_GAP      = 3'd2;
	localparam logic [2:0] ST_BAD_VER  = 3'd3;
	localparam logic [2:0] ST_UNK_ID   = 3'd4;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_GAP  = 1'b1;

	localparam logic [1:0] REG_START_MARKER = 2'd0;
	localparam logic [1:0] REG_EXP_VERSION  = 2'd1;
	localparam logic [1:0] REG_CMD_LIMIT    = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  version_seen;
		logic [7:0]  command_id;
		logic [31:0] parameter_value;
		logic [15:0] sequence_number;
		logic [15:0] resync_count;
	} out_item_t;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] expected_version;
		logic [7:0] command_limit;
	} cfg_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       store_byte;
		logic       clear_fill;
		logic       shift;
		logic       crc_init;
		logic       crc_step;
		logic       bump;
		logic       pend_load;
		logic [2:0] pend_status;
		logic       load_out;
	} ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic       fill_zero;
		logic       fill_last;
		logic       byte_is_marker;
		logic       head_is_marker;
		logic       crc_last;
		logic       crc_match;
		logic [2:0] verdict;
		logic       out_free;
	} sts_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/command_frame_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Fixed-length command frame deframer. Each input beat is a received byte or an idle gap.
// Bytes are dropped until the start marker, then collected into a 13-byte frame whose
// first 9 bytes are checked with the reflected IEEE CRC-32 against the big-endian trailer.
// A byte that completes no frame leaves the controller idle. The byte that completes
// a frame starts a CRC pass through one shared byte-wide CRC unit, one body byte per
// cycle, then a verdict; a frame whose CRC matches is loaded into the output register
// from the emit state once that register is free, and the next beat is taken once the
// controller is back in idle. On a CRC failure the buffer shifts down one byte per cycle
// until the next start marker or until empty. A gap that abandons a frame is loaded
// into the output register from the emit state. A finished result waits, and holds off
// the input, while the output register still holds a result that has not been collected.
// Input is taken only while the controller is idle; the output register holds a finished
// result so the next byte can be taken before that result is collected. Configuration
// registers: 0x0 start marker, 0x4 expected version, 0x8 command limit (low 8 bits).
module command_frame_deframer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  cfd_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output cfd_pkg::out_item_t   out_data,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [3:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import cfd_pkg::*;

	cfg_t cfg;
	ctl_t ctl;
	sts_t sts;

	cfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	cfd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (in_data.rx_byte),
		.cfg       (cfg),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/cfd_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cfd_regs (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [3:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfd_pkg::cfg_t     cfg
);
	import cfd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker     <= 8'd0;
			cfg_q.expected_version <= 8'd1;
			cfg_q.command_limit    <= 8'd11;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_START_MARKER: cfg_q.start_marker     <= pwdata[7:0];
				REG_EXP_VERSION:  cfg_q.expected_version <= pwdata[7:0];
				REG_CMD_LIMIT:    cfg_q.command_limit    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_MARKER: prdata = {24'd0, cfg_q.start_marker};
			REG_EXP_VERSION:  prdata = {24'd0, cfg_q.expected_version};
			REG_CMD_LIMIT:    prdata = {24'd0, cfg_q.command_limit};
			default:          prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/cfd_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cfd_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [7:0]           rx_byte,
	input  cfd_pkg::cfg_t        cfg,
	input  cfd_pkg::ctl_t        ctl,
	output cfd_pkg::sts_t        sts,
	output logic                 out_valid,
	input  wire                  out_ready,
	output cfd_pkg::out_item_t   out_data
);
	import cfd_pkg::*;

	logic [7:0]  store_q [FRAME_LEN];
	logic [3:0]  fill_q;
	logic [31:0] crc_q;
	logic [3:0]  idx_q;
	logic [15:0] resync_q;
	logic [2:0]  pend_q;
	logic        out_valid_q;
	out_item_t   out_q;
	out_item_t   result;
	logic [31:0] crc_rx;
	logic        with_frame;

	always_ff @(posedge clk) begin
		if (ctl.store_byte) begin
			store_q[fill_q] <= rx_byte;
		end else if (ctl.shift) begin
			for (int k = 0; k < FRAME_LEN - 1; k++) begin
				store_q[k] <= store_q[k + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 4'd0;
		end else if (ctl.clear_fill) begin
			fill_q <= 4'd0;
		end else if (ctl.store_byte) begin
			fill_q <= fill_q + 4'd1;
		end else if (ctl.shift) begin
			fill_q <= fill_q - 4'd1;
		end
	end

	// crc pass over the frame body, one byte per cycle
	always_ff @(posedge clk) begin
		if (ctl.crc_init) begin
			crc_q <= CRC_INIT;
			idx_q <= 4'd0;
		end else if (ctl.crc_step) begin
			crc_q <= crc_byte(crc_q, store_q[idx_q]);
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resync_q <= 16'd0;
		end else if (ctl.bump && resync_q != 16'hFFFF) begin
			resync_q <= resync_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= ST_OK;
		end else if (ctl.pend_load) begin
			pend_q <= ctl.pend_status;
		end
	end

	assign crc_rx = {store_q[BODY_LEN], store_q[BODY_LEN + 1],
			store_q[BODY_LEN + 2], store_q[BODY_LEN + 3]};

	always_comb begin
		with_frame = (pend_q == ST_OK) || (pend_q == ST_BAD_VER) || (pend_q == ST_UNK_ID);
		result.status       = pend_q;
		result.resync_count = resync_q;
		if (with_frame) begin
			result.version_seen    = store_q[1];
			result.command_id      = store_q[2];
			result.parameter_value = {store_q[3], store_q[4], store_q[5], store_q[6]};
			result.sequence_number = {store_q[7], store_q[8]};
		end else begin
			result.version_seen    = 8'd0;
			result.command_id      = 8'd0;
			result.parameter_value = 32'd0;
			result.sequence_number = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.fill_zero      = (fill_q == 4'd0);
		sts.fill_last      = (fill_q == 4'(FRAME_LEN - 1));
		sts.byte_is_marker = (rx_byte == cfg.start_marker);
		sts.head_is_marker = (store_q[0] == cfg.start_marker);
		sts.crc_last       = (idx_q == 4'(BODY_LEN - 1));
		sts.crc_match      = ((crc_q ^ CRC_INIT) == crc_rx);
		if (store_q[1] != cfg.expected_version) begin
			sts.verdict = ST_BAD_VER;
		end else if (store_q[2] >= cfg.command_limit) begin
			sts.verdict = ST_UNK_ID;
		end else begin
			sts.verdict = ST_OK;
		end
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/cfd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cfd_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  wire            in_kind,
	output logic           in_ready,
	input  cfd_pkg::sts_t  sts,
	output cfd_pkg::ctl_t  ctl
);
	import cfd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CRC   = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_nx        = state_q;
		ctl             = '0;
		ctl.pend_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_kind == KIND_GAP) begin
						if (!sts.fill_zero) begin
							ctl.clear_fill  = 1'b1;
							ctl.bump        = 1'b1;
							ctl.pend_load   = 1'b1;
							ctl.pend_status = ST_GAP;
							state_nx        = S_EMIT;
						end
					end else if (!sts.fill_zero || sts.byte_is_marker) begin
						ctl.store_byte = 1'b1;
						if (sts.fill_last) begin
							ctl.crc_init = 1'b1;
							state_nx     = S_CRC;
						end
					end
				end
			end
			S_CRC: begin
				ctl.crc_step = 1'b1;
				if (sts.crc_last) begin
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.pend_load = 1'b1;
				if (sts.crc_match) begin
					ctl.pend_status = sts.verdict;
					ctl.clear_fill  = 1'b1;
					state_nx        = S_EMIT;
				end else begin
					// drop the first byte, then hunt for the next marker
					ctl.pend_status = ST_CRC_ERR;
					ctl.bump        = 1'b1;
					ctl.shift       = 1'b1;
					state_nx        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.fill_zero || sts.head_is_marker) begin
					state_nx = S_EMIT;
				end else begin
					ctl.shift = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire
